### src/spmt_pkg.sv
`default_nettype none

package spmt_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam int MODE_W  = 2;
    localparam int PROG_W  = 32;
    localparam int VERS_W  = 32;
    localparam int PROT_W  = 8;
    localparam int PORT_W  = 16;

    // request fields packed from the lowest bit up, padded to whole bytes
    localparam int S_FIELDS_W = MODE_W + PROG_W + VERS_W + PROT_W + PORT_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + PORT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_NULL    = 2'd0,
        MODE_SET     = 2'd1,
        MODE_UNSET   = 2'd2,
        MODE_GETPORT = 2'd3
    } mode_t;

    // one table slot as it moves between neighbouring cells
    typedef struct packed {
        logic              kill;
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [PROT_W-1:0] prot;
        logic [VERS_W-1:0] vers;
        logic [PROG_W-1:0] prog;
    } entry_t;

    typedef struct packed {
        logic              capture;
        logic              insert;
        logic              shift;
        mode_t             mode;
        logic [PROG_W-1:0] prog;
        logic [VERS_W-1:0] vers;
        logic [PROT_W-1:0] prot;
        logic [PORT_W-1:0] port;
    } cell_ctrl_t;

    typedef struct packed {
        logic exact;
        logic prog_prot;
        logic port_eq;
    } cell_flags_t;

    typedef struct packed {
        logic              any_exact;
        logic              exact_port_eq;
        logic              any_kill;
        logic [PORT_W-1:0] found_port;
    } pick_t;

endpackage

`default_nettype wire

### src/spmt_cell.sv
`default_nettype none

module spmt_cell (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire spmt_pkg::cell_ctrl_t  ctrl,
    input  wire spmt_pkg::entry_t      up_entry,
    output spmt_pkg::entry_t           entry,
    output spmt_pkg::cell_flags_t      flags
);
    import spmt_pkg::*;

    logic [PROG_W-1:0] prog_reg, prog_next;
    logic [VERS_W-1:0] vers_reg, vers_next;
    logic [PROT_W-1:0] prot_reg, prot_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic              valid_reg, valid_next;
    logic              kill_reg, kill_next;
    cell_flags_t       flags_reg, flags_next;
    logic              prog_eq;
    logic              vers_eq;
    logic              prot_eq;

    assign prog_eq = (prog_reg == ctrl.prog);
    assign vers_eq = (vers_reg == ctrl.vers);
    assign prot_eq = (prot_reg == ctrl.prot);

    always_comb
    begin
        prog_next  = prog_reg;
        vers_next  = vers_reg;
        prot_next  = prot_reg;
        port_next  = port_reg;
        valid_next = valid_reg;
        kill_next  = kill_reg;
        flags_next = flags_reg;
        if (ctrl.capture)
        begin
            flags_next.exact     = valid_reg & prog_eq & vers_eq & prot_eq;
            flags_next.prog_prot = valid_reg & prog_eq & prot_eq;
            flags_next.port_eq   = (port_reg == ctrl.port);
            kill_next            = valid_reg & prog_eq & vers_eq
                                   & (ctrl.mode == MODE_UNSET);
        end
        else if (ctrl.insert)
        begin
            prog_next  = ctrl.prog;
            vers_next  = ctrl.vers;
            prot_next  = ctrl.prot;
            port_next  = ctrl.port;
            valid_next = 1'b1;
        end
        else if (ctrl.shift)
        begin
            // take the younger neighbour's slot, closing the gap
            prog_next  = up_entry.prog;
            vers_next  = up_entry.vers;
            prot_next  = up_entry.prot;
            port_next  = up_entry.port;
            valid_next = up_entry.valid;
            kill_next  = up_entry.kill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            kill_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            kill_reg  <= kill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prog_reg  <= prog_next;
        vers_reg  <= vers_next;
        prot_reg  <= prot_next;
        port_reg  <= port_next;
        flags_reg <= flags_next;
    end

    assign entry.kill  = kill_reg;
    assign entry.valid = valid_reg;
    assign entry.port  = port_reg;
    assign entry.prot  = prot_reg;
    assign entry.vers  = vers_reg;
    assign entry.prog  = prog_reg;
    assign flags       = flags_reg;

endmodule

`default_nettype wire

### src/spmt_pick.sv
`default_nettype none

module spmt_pick #(
    parameter int ENTRIES = spmt_pkg::ENTRIES_DEF
) (
    input  wire  [ENTRIES-1:0]          exact,
    input  wire  [ENTRIES-1:0]          prog_prot,
    input  wire  [ENTRIES-1:0]          port_eq,
    input  wire  [ENTRIES-1:0]          kill,
    input  wire  [spmt_pkg::PORT_W-1:0] ports [ENTRIES],
    output spmt_pkg::pick_t             pick,
    output logic [ENTRIES-1:0]          shift_mask
);
    import spmt_pkg::*;

    logic [ENTRIES-1:0] pp_first;
    logic [ENTRIES-1:0] kill_first;
    logic [PORT_W-1:0]  exact_port;
    logic [PORT_W-1:0]  pp_port;

    // oldest slot wins: isolate the lowest set bit
    assign pp_first   = prog_prot & (~prog_prot + 1'b1);
    assign kill_first = kill & (~kill + 1'b1);
    // every slot from the oldest marked one upward moves down by one
    assign shift_mask = ~(kill_first - 1'b1);

    always_comb
    begin
        exact_port = '0;
        pp_port    = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            exact_port = exact_port | (ports[i] & {PORT_W{exact[i]}});
            pp_port    = pp_port    | (ports[i] & {PORT_W{pp_first[i]}});
        end
    end

    // an exact match is unique, so a plain or-reduction selects it
    assign pick.any_exact     = |exact;
    assign pick.exact_port_eq = |(exact & port_eq);
    assign pick.any_kill      = |kill;
    assign pick.found_port    = (|exact) ? exact_port : pp_port;

endmodule

`default_nettype wire

### src/service_port_mapping_table.sv
`default_nettype none

// service port mapping table: an age-ordered table of up to ENTRIES mappings
// from (program, version, protocol) to a port, held in a row of identical
// cells, slot 0 the oldest. a request transaction on the s_ side names an
// operation (null, set, unset, getport) and always yields exactly one result
// transaction on the m_ side. in the cycle a request is taken every cell
// compares its slot with the request and registers its match flags; in the
// next cycle the flags are reduced, a set with no exact match writes the first
// free cell unless the table is full, and the result is loaded into the
// output register if that is free and no slot is marked. unset marks every
// slot with the same program and version; the marked slots are then squeezed
// out one per cycle, each cell taking its younger neighbour's contents, and
// the result is loaded once no marked slot remains and the output register
// is free. the block takes one request at a time and is ready again once the
// result sits in the output register; a stalled m_ side holds the block
// until the previous result is taken. the table is empty after reset, with
// no clearing pass.
module service_port_mapping_table #(
    parameter int ENTRIES = spmt_pkg::ENTRIES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // mode[1:0], program_req[33:2], version[65:34], protocol[73:66], port[89:74]
    input  wire  [spmt_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // ok[0], found_port[16:1]
    output logic [spmt_pkg::M_TDATA_W-1:0]   m_tdata
);
    import spmt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic                   res_ok_reg, res_ok_next;
    logic [PORT_W-1:0]      res_port_reg, res_port_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // request fields unpacked from the slave transaction
    mode_t                  req_mode;
    logic [PROG_W-1:0]      req_prog;
    logic [VERS_W-1:0]      req_vers;
    logic [PROT_W-1:0]      req_prot;
    logic [PORT_W-1:0]      req_port;

    // request fields held for the insert of a set
    logic [PROG_W-1:0]      cell_prog_hold;
    logic [VERS_W-1:0]      cell_vers_hold;
    logic [PROT_W-1:0]      cell_prot_hold;
    logic [PORT_W-1:0]      cell_port_hold;

    logic                   accept;
    logic                   out_free;
    logic                   insert_go;
    logic                   shift_go;
    logic                   full;
    logic                   calc_ok;
    logic [PORT_W-1:0]      calc_port;

    entry_t                 cell_entry [ENTRIES];
    cell_flags_t            cell_flags [ENTRIES];
    cell_ctrl_t             cell_ctrl  [ENTRIES];
    logic [ENTRIES-1:0]     valid_vec;
    logic [ENTRIES-1:0]     exact_vec;
    logic [ENTRIES-1:0]     pp_vec;
    logic [ENTRIES-1:0]     peq_vec;
    logic [ENTRIES-1:0]     kill_vec;
    logic [ENTRIES-1:0]     first_free;
    logic [ENTRIES-1:0]     shift_mask;
    logic [PORT_W-1:0]      port_vec [ENTRIES];
    pick_t                  pick;

    assign req_mode = mode_t'(s_tdata[MODE_W-1:0]);
    assign req_prog = s_tdata[MODE_W +: PROG_W];
    assign req_vers = s_tdata[MODE_W+PROG_W +: VERS_W];
    assign req_prot = s_tdata[MODE_W+PROG_W+VERS_W +: PROT_W];
    assign req_port = s_tdata[MODE_W+PROG_W+VERS_W+PROT_W +: PORT_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;

    // valid slots are packed from slot 0, so the first free one is one-hot
    assign first_free = ~valid_vec & ((valid_vec << 1) | ENTRIES'(1'b1));
    assign full       = valid_vec[ENTRIES-1];

    assign insert_go = (state_reg == ST_RESOLVE) && (mode_reg == MODE_SET)
                       && !pick.any_exact && !full;
    assign shift_go  = (state_reg == ST_FINISH) && pick.any_kill;

    // the row of cells; the youngest cell is fed an empty slot
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        entry_t up_entry;

        if (g == ENTRIES - 1)
        begin : g_tail
            assign up_entry = '0;
        end
        else
        begin : g_link
            assign up_entry = cell_entry[g+1];
        end

        assign cell_ctrl[g].capture = accept;
        assign cell_ctrl[g].insert  = insert_go & first_free[g];
        assign cell_ctrl[g].shift   = shift_go & shift_mask[g];
        assign cell_ctrl[g].mode    = req_mode;
        assign cell_ctrl[g].prog    = insert_go ? cell_prog_hold : req_prog;
        assign cell_ctrl[g].vers    = insert_go ? cell_vers_hold : req_vers;
        assign cell_ctrl[g].prot    = insert_go ? cell_prot_hold : req_prot;
        assign cell_ctrl[g].port    = insert_go ? cell_port_hold : req_port;

        spmt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl[g]),
            .up_entry (up_entry),
            .entry    (cell_entry[g]),
            .flags    (cell_flags[g])
        );

        assign valid_vec[g] = cell_entry[g].valid;
        assign kill_vec[g]  = cell_entry[g].kill;
        assign exact_vec[g] = cell_flags[g].exact;
        assign pp_vec[g]    = cell_flags[g].prog_prot;
        assign peq_vec[g]   = cell_flags[g].port_eq;
        assign port_vec[g]  = cell_entry[g].port;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cell_prog_hold <= req_prog;
            cell_vers_hold <= req_vers;
            cell_prot_hold <= req_prot;
            cell_port_hold <= req_port;
        end
    end

    spmt_pick #(
        .ENTRIES (ENTRIES)
    ) u_pick (
        .exact      (exact_vec),
        .prog_prot  (pp_vec),
        .port_eq    (peq_vec),
        .kill       (kill_vec),
        .ports      (port_vec),
        .pick       (pick),
        .shift_mask (shift_mask)
    );

    // result of the transaction once the match flags are in
    always_comb
    begin
        calc_ok   = 1'b1;
        calc_port = '0;
        unique case (mode_reg)
            MODE_SET:
            begin
                calc_ok = pick.any_exact ? pick.exact_port_eq : ~full;
            end
            MODE_UNSET:
            begin
                calc_ok = pick.any_kill;
            end
            MODE_GETPORT:
            begin
                calc_port = pick.found_port;
            end
            default:
            begin
                calc_ok = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        res_ok_next   = res_ok_reg;
        res_port_next = res_port_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = req_mode;
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                res_ok_next   = calc_ok;
                res_port_next = calc_port;
                if (out_free && !pick.any_kill)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({calc_port, calc_ok});
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // squeeze out marked slots, then hand over the result
                if (!pick.any_kill && out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({res_port_reg, res_ok_reg});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        res_ok_reg   <= res_ok_next;
        res_port_reg <= res_port_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
